>>> rtl/ppat_pkg.sv
// Shared types and constants for the peer presence aging table.
`default_nettype none
package ppat_pkg;

    localparam int CAPACITY_DEF    = 8;
    localparam int GENERATIONS_DEF = 2;
    localparam int KEY_W           = 48;
    localparam int PORT_W          = 16;
    localparam int KIND_W          = 2;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = 1;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_REPLY = 1'b1
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        EV_ADDED   = 2'd0,
        EV_REMOVED = 2'd1,
        EV_DROPPED = 2'd2
    } t_kind;

    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [PORT_W-1:0] port;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_FIN,
        S_ADD
    } t_state;

endpackage
`default_nettype wire

>>> rtl/ppat_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ppat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/ppat_front.sv
// Front end: accepts transactions, decodes the opcode and queues commands.
`default_nettype none
module ppat_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_opcode,
    input  wire logic [ppat_pkg::KEY_W-1:0]  i_peer_key,
    input  wire logic [ppat_pkg::PORT_W-1:0] i_service_port,
    output logic                           o_cmd_vld,
    output ppat_pkg::t_cmd                 o_cmd,
    input  wire logic                      i_cmd_pop
);
    import ppat_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QPTR_W:0]   r_cnt, n_cnt;
    logic              push;
    logic              pop;
    t_cmd              in_cmd;

    always_comb begin
        in_cmd.op   = t_op'(i_opcode);
        in_cmd.key  = i_peer_key;
        in_cmd.port = i_service_port;
    end

    assign busy      = (r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign push      = start && !busy;
    assign o_cmd_vld = (r_cnt != '0);
    assign pop       = i_cmd_pop && o_cmd_vld;
    assign o_cmd     = r_q[r_rp];

    always_comb begin
        n_wp  = push ? r_wp + QPTR_W'(1) : r_wp;
        n_rp  = pop ? r_rp + QPTR_W'(1) : r_rp;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + (QPTR_W + 1)'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

>>> rtl/ppat_back.sv
// Back end: sequencer that looks up, appends and ages table entries.
`default_nettype none
module ppat_back #(
    parameter int CAPACITY    = ppat_pkg::CAPACITY_DEF,
    parameter int GENERATIONS = ppat_pkg::GENERATIONS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cmd_vld,
    input  wire ppat_pkg::t_cmd              i_cmd,
    output logic                             o_cmd_pop,
    output logic                             o_strobe,
    output logic [ppat_pkg::KIND_W-1:0]      o_event_kind,
    output logic [ppat_pkg::KEY_W-1:0]       o_peer_key_res,
    output logic [ppat_pkg::PORT_W-1:0]      o_service_port_res,
    output logic                             o_last
);
    import ppat_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = KEY_W + GENERATIONS;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_w, n_w;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_pend_vld, n_pend_vld;
    logic [KEY_W-1:0]   r_pend_key, n_pend_key;
    logic               r_out_vld, n_out_vld;
    t_kind              r_kind, n_kind;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [PORT_W-1:0]  r_port, n_port;
    logic               r_last, n_last;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic [ENT_W-1:0]   ram_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [GENERATIONS-1:0] rd_seen;
    logic [GENERATIONS-1:0] seen_shift;
    logic [GENERATIONS-1:0] seen_mark;
    logic               at_end;
    logic               hit;
    logic               full;

    ppat_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_key     = ram_rdata[ENT_W-1:GENERATIONS];
    assign rd_seen    = ram_rdata[GENERATIONS-1:0];
    assign seen_shift = rd_seen << 1;
    assign seen_mark  = rd_seen | GENERATIONS'(1);
    assign at_end     = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));
    assign hit        = (rd_key == r_cmd.key);
    assign full       = (r_count == CNT_W'(CAPACITY));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_vld) begin
                    if (r_count != '0) begin
                        n_state = S_RD;
                    end else if (i_cmd.op == OP_REPLY) begin
                        n_state = S_ADD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_cmd.op == OP_REPLY) begin
                    if (hit) begin
                        n_state = S_IDLE;
                    end else if (at_end) begin
                        n_state = S_ADD;
                    end else begin
                        n_state = S_RD;
                    end
                end else begin
                    n_state = at_end ? S_FIN : S_RD;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            S_ADD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_w        = r_w;
        n_count    = r_count;
        n_pend_vld = r_pend_vld;
        n_pend_key = r_pend_key;
        n_out_vld  = 1'b0;
        n_kind     = r_kind;
        n_key      = r_key;
        n_port     = r_port;
        n_last     = r_last;
        o_cmd_pop  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_w[IDX_W-1:0];
        ram_wdata  = {r_cmd.key, GENERATIONS'(1)};
        case (r_state)
            S_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_pop  = 1'b1;
                    n_cmd      = i_cmd;
                    n_idx      = '0;
                    n_w        = '0;
                    n_pend_vld = 1'b0;
                end
            end
            S_CMP: begin
                if (r_cmd.op == OP_REPLY) begin
                    if (hit) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_idx;
                        ram_wdata = {rd_key, seen_mark};
                    end else if (!at_end) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    if (rd_seen == '0) begin
                        // removal is held back one step so the last flag is known
                        if (r_pend_vld) begin
                            n_out_vld = 1'b1;
                            n_kind    = EV_REMOVED;
                            n_key     = r_pend_key;
                            n_port    = '0;
                            n_last    = 1'b0;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_key = rd_key;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_w[IDX_W-1:0];
                        ram_wdata = {rd_key, seen_shift};
                        n_w       = r_w + CNT_W'(1);
                    end
                    if (!at_end) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_FIN: begin
                n_count    = r_w;
                n_pend_vld = 1'b0;
                if (r_pend_vld) begin
                    n_out_vld = 1'b1;
                    n_kind    = EV_REMOVED;
                    n_key     = r_pend_key;
                    n_port    = '0;
                    n_last    = 1'b1;
                end
            end
            S_ADD: begin
                n_out_vld = 1'b1;
                n_key     = r_cmd.key;
                n_last    = 1'b1;
                if (!full) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_count[IDX_W-1:0];
                    ram_wdata = {r_cmd.key, GENERATIONS'(1)};
                    n_count   = r_count + CNT_W'(1);
                    n_kind    = EV_ADDED;
                    n_port    = r_cmd.port;
                end else begin
                    n_kind = EV_DROPPED;
                    n_port = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_w        <= n_w;
        r_pend_key <= n_pend_key;
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_port     <= n_port;
        r_last     <= n_last;
    end

    assign o_strobe           = r_out_vld;
    assign o_event_kind       = r_kind;
    assign o_peer_key_res     = r_key;
    assign o_service_port_res = r_port;
    assign o_last             = r_last;

endmodule
`default_nettype wire

>>> rtl/peer_presence_aging_table.sv
// Top level of the peer presence aging table.
// A transaction is taken when start is high and busy is low; busy rises only when the
// two-entry command queue is full. Peers are kept compacted in a RAM in arrival order,
// with a fill count marking the live entries, so no clearing pass follows reset. The
// back end reads and compares the stored entries one at a time (S_RD, then S_CMP) and
// pops the next command only from S_IDLE. Each event appears on the o_ ports for one
// cycle with o_strobe high and must be captured then; o_last marks the final event of
// a transaction. Removals come out oldest first; the last one of a tick may follow the
// one before it in the next cycle.
`default_nettype none
module peer_presence_aging_table #(
    parameter int CAPACITY    = ppat_pkg::CAPACITY_DEF,
    parameter int GENERATIONS = ppat_pkg::GENERATIONS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_opcode,
    input  wire logic [ppat_pkg::KEY_W-1:0]  i_peer_key,
    input  wire logic [ppat_pkg::PORT_W-1:0] i_service_port,
    output logic                             o_strobe,
    output logic [ppat_pkg::KIND_W-1:0]      o_event_kind,
    output logic [ppat_pkg::KEY_W-1:0]       o_peer_key_res,
    output logic [ppat_pkg::PORT_W-1:0]      o_service_port_res,
    output logic                             o_last
);
    import ppat_pkg::*;

    logic cmd_vld;
    logic cmd_pop;
    t_cmd cmd;

    ppat_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_peer_key     (i_peer_key),
        .i_service_port (i_service_port),
        .o_cmd_vld      (cmd_vld),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    ppat_back #(
        .CAPACITY    (CAPACITY),
        .GENERATIONS (GENERATIONS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd_vld          (cmd_vld),
        .i_cmd              (cmd),
        .o_cmd_pop          (cmd_pop),
        .o_strobe           (o_strobe),
        .o_event_kind       (o_event_kind),
        .o_peer_key_res     (o_peer_key_res),
        .o_service_port_res (o_service_port_res),
        .o_last             (o_last)
    );

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the peer presence aging table: directed rows, then random traffic.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppat_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int GEN = GENERATIONS_DEF;
    localparam int POOL_SIZE = 10;
    localparam int ITEMS_PER_PHASE = 50;

    typedef struct {
        t_kind             kind;
        logic [KEY_W-1:0]  key;
        logic [PORT_W-1:0] port;
        logic              last;
    } t_presence_event;

    typedef enum int {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } t_chk;

    typedef struct {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [PORT_W-1:0] port;
        t_chk              chk;
        t_kind             kind;
        logic [KEY_W-1:0]  ev_key;
        logic [PORT_W-1:0] ev_port;
    } t_dir_row;

    localparam int DIR_ROWS = 20;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_opcode = 1'b0;
    logic [KEY_W-1:0]  i_peer_key = '0;
    logic [PORT_W-1:0] i_service_port = '0;
    logic              o_strobe;
    logic [KIND_W-1:0] o_event_kind;
    logic [KEY_W-1:0]  o_peer_key_res;
    logic [PORT_W-1:0] o_service_port_res;
    logic              o_last;

    // predictor copy of the peer table
    logic [KEY_W-1:0]  tbl_key   [CAP];
    logic              tbl_valid [CAP];
    logic [GEN-1:0]    tbl_seen  [CAP];

    t_presence_event   step_events[$];
    t_presence_event   pending_events[$];
    int                mismatch_count = 0;
    logic [KEY_W-1:0]  peer_pool [POOL_SIZE];
    t_dir_row          dir_rows [DIR_ROWS];

    peer_presence_aging_table uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_peer_key         (i_peer_key),
        .i_service_port     (i_service_port),
        .o_strobe           (o_strobe),
        .o_event_kind       (o_event_kind),
        .o_peer_key_res     (o_peer_key_res),
        .o_service_port_res (o_service_port_res),
        .o_last             (o_last)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

    // Table update for one transaction; the events it causes land in step_events.
    function automatic void age_and_track(input t_op op, input logic [KEY_W-1:0] key,
                                          input logic [PORT_W-1:0] port);
        int              w;
        bit              done;
        t_presence_event ev;
        step_events = {};
        done = 1'b0;
        if (op == OP_TICK) begin
            w = 0;
            for (int r = 0; r < CAP; r++) begin
                if (tbl_valid[r]) begin
                    if (tbl_seen[r] == '0) begin
                        ev = '{EV_REMOVED, tbl_key[r], '0, 1'b0};
                        step_events = {step_events, ev};
                    end else begin
                        tbl_key[w]   = tbl_key[r];
                        tbl_seen[w]  = tbl_seen[r] << 1;
                        tbl_valid[w] = 1'b1;
                        w++;
                    end
                end
            end
            for (int r = w; r < CAP; r++) begin
                tbl_valid[r] = 1'b0;
                tbl_seen[r]  = '0;
            end
        end else begin
            for (int i = 0; i < CAP; i++) begin
                if (!done && tbl_valid[i] && tbl_key[i] == key) begin
                    tbl_seen[i] = tbl_seen[i] | GEN'(1);
                    done = 1'b1;
                end
            end
            for (int i = 0; i < CAP; i++) begin
                if (!done && !tbl_valid[i]) begin
                    tbl_valid[i] = 1'b1;
                    tbl_key[i]   = key;
                    tbl_seen[i]  = GEN'(1);
                    ev = '{EV_ADDED, key, port, 1'b0};
                    step_events = {step_events, ev};
                    done = 1'b1;
                end
            end
            if (!done) begin
                ev = '{EV_DROPPED, key, '0, 1'b0};
                step_events = {step_events, ev};
            end
        end
        if (step_events.size() > 0) begin
            ev = step_events[step_events.size() - 1];
            ev.last = 1'b1;
            step_events[step_events.size() - 1] = ev;
        end
    endfunction

    task automatic send_transaction(input t_op op, input logic [KEY_W-1:0] key,
                                    input logic [PORT_W-1:0] port, input int idle_pct);
        bit lowered;
        lowered = 1'b0;
        while ($urandom_range(99) < idle_pct) begin
            if (!lowered) begin
                start   <= 1'b0;
                lowered = 1'b1;
            end
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_opcode       <= op;
        i_peer_key     <= key;
        i_service_port <= port;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_presence_event want;
        if (i_rst_n && o_strobe) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event: got kind %0d key %h port %h last %0d",
                         $time, o_event_kind, o_peer_key_res, o_service_port_res, o_last);
                mismatch_count++;
            end else begin
                want = pending_events.pop_front();
                if (o_event_kind !== want.kind || o_peer_key_res !== want.key ||
                    o_service_port_res !== want.port || o_last !== want.last) begin
                    $display("%0t: event mismatch: expected kind %0d key %h port %h last %0d",
                             $time, want.kind, want.key, want.port, want.last);
                    $display("%0t:                 actual   kind %0d key %h port %h last %0d",
                             $time, o_event_kind, o_peer_key_res, o_service_port_res,
                             o_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [PORT_W-1:0] port;
        t_presence_event   ev;
        int                roll;
        int                waited;
        int                idle_pct [3];

        idle_pct = '{17, 50, 0};
        for (int i = 0; i < CAP; i++) begin
            tbl_key[i]   = '0;
            tbl_valid[i] = 1'b0;
            tbl_seen[i]  = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            peer_pool[i] = {16'($urandom()), 32'($urandom())};
        end

        dir_rows = '{
            '{OP_TICK,  48'h0,              16'h0,    CHK_NONE,  EV_ADDED,   48'h0, 16'h0},
            '{OP_REPLY, 48'h0,              16'h0,    CHK_ONE,   EV_ADDED,
              48'h0,              16'h0},
            '{OP_REPLY, 48'hFFFF_FFFF_FFFF, 16'hFFFF, CHK_ONE,   EV_ADDED,
              48'hFFFF_FFFF_FFFF, 16'hFFFF},
            '{OP_REPLY, 48'h0,              16'h1234, CHK_NONE,  EV_ADDED,   48'h0, 16'h0},
            '{OP_REPLY, 48'hAAAA_AAAA_AAAA, 16'h5555, CHK_ONE,   EV_ADDED,
              48'hAAAA_AAAA_AAAA, 16'h5555},
            '{OP_REPLY, 48'h5555_5555_5555, 16'hAAAA, CHK_ONE,   EV_ADDED,
              48'h5555_5555_5555, 16'hAAAA},
            '{OP_REPLY, 48'hC0A8_0001_1F90, 16'h0050, CHK_ONE,   EV_ADDED,
              48'hC0A8_0001_1F90, 16'h0050},
            '{OP_REPLY, 48'h0A00_0002_0001, 16'h0001, CHK_ONE,   EV_ADDED,
              48'h0A00_0002_0001, 16'h0001},
            '{OP_REPLY, 48'h0000_0000_0001, 16'h8000, CHK_ONE,   EV_ADDED,
              48'h0000_0000_0001, 16'h8000},
            '{OP_REPLY, 48'h8000_0000_0000, 16'h7FFF, CHK_ONE,   EV_ADDED,
              48'h8000_0000_0000, 16'h7FFF},
            '{OP_REPLY, 48'h7FFF_FFFF_FFFF, 16'hABCD, CHK_ONE,   EV_DROPPED,
              48'h7FFF_FFFF_FFFF, 16'h0},
            '{OP_TICK,  48'h0,              16'h0,    CHK_MODEL, EV_ADDED,   48'h0, 16'h0},
            '{OP_REPLY, 48'hFFFF_FFFF_FFFF, 16'h0,    CHK_MODEL, EV_ADDED,   48'h0, 16'h0},
            '{OP_TICK,  48'h0,              16'h0,    CHK_MODEL, EV_ADDED,   48'h0, 16'h0},
            '{OP_TICK,  48'h0,              16'h0,    CHK_MODEL, EV_ADDED,   48'h0, 16'h0},
            '{OP_REPLY, 48'h1234_5678_9ABC, 16'h0,    CHK_MODEL, EV_ADDED,   48'h0, 16'h0},
            '{OP_TICK,  48'hFFFF_FFFF_FFFF, 16'hFFFF, CHK_MODEL, EV_ADDED,   48'h0, 16'h0},
            '{OP_TICK,  48'h0,              16'h0,    CHK_MODEL, EV_ADDED,   48'h0, 16'h0},
            '{OP_TICK,  48'h0,              16'h0,    CHK_MODEL, EV_ADDED,   48'h0, 16'h0},
            '{OP_TICK,  48'h0,              16'h0,    CHK_NONE,  EV_ADDED,   48'h0, 16'h0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) begin
            send_transaction(dir_rows[n].op, dir_rows[n].key, dir_rows[n].port, 17);
            age_and_track(dir_rows[n].op, dir_rows[n].key, dir_rows[n].port);
            case (dir_rows[n].chk)
                CHK_MODEL: begin
                    pending_events = {pending_events, step_events};
                end
                CHK_ONE: begin
                    ev = '{dir_rows[n].kind, dir_rows[n].ev_key, dir_rows[n].ev_port, 1'b1};
                    pending_events = {pending_events, ev};
                end
                default: ;
            endcase
        end

        // pool keys outnumber the table so the full and aging paths stay busy
        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(99);
                key  = {16'($urandom()), 32'($urandom())};
                port = 16'($urandom());
                if (roll < 25) begin
                    op = OP_TICK;
                end else begin
                    op = OP_REPLY;
                    if (roll < 92) key = peer_pool[$urandom_range(POOL_SIZE - 1)];
                end
                send_transaction(op, key, port, idle_pct[phase]);
                age_and_track(op, key, port);
                pending_events = {pending_events, step_events};
            end
        end
        start <= 1'b0;

        waited = 0;
        while (pending_events.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_events.size() != 0) begin
            $display("%0t: %0d expected events never arrived", $time, pending_events.size());
            mismatch_count++;
        end
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
